// ----- src/dq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_PEEK       = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  // one-hot shift/load command broadcast to every cell
  typedef struct packed {
    logic clear;
    logic add_front;
    logic take_front;
    logic add_back;
    logic take_back;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- src/dq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dq_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dq_pkg::cell_ctl_t                ctl_i,
  input  logic [dq_pkg::WORD_WIDTH-1:0]    push_value_i,
  input  logic                             left_valid_i,
  input  logic [dq_pkg::WORD_WIDTH-1:0]    left_data_i,
  input  logic                             right_valid_i,
  input  logic [dq_pkg::WORD_WIDTH-1:0]    right_data_i,
  output logic                             valid_o,
  output logic [dq_pkg::WORD_WIDTH-1:0]    data_o,
  output logic                             last_o
);
  import dq_pkg::*;

  logic                  valid_q, valid_d;
  logic [WORD_WIDTH-1:0] data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.add_front) begin
      valid_d = left_valid_i;
      data_d  = left_data_i;
    end else if (ctl_i.take_front) begin
      valid_d = right_valid_i;
      data_d  = right_data_i;
    end else if (ctl_i.add_back) begin
      // first free cell takes the new item
      if (!valid_q && left_valid_i) begin
        valid_d = 1'b1;
        data_d  = push_value_i;
      end
    end else if (ctl_i.take_back) begin
      if (valid_q && !right_valid_i) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign last_o  = valid_q && !right_valid_i;

endmodule

`default_nettype wire

// ----- src/double_ended_queue_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of up to DEPTH words, held in a row of cells
// with the front always in cell 0. Front pushes and pops shift the whole row
// by one cell; back pushes and pops touch only the cell at the fill boundary.
// Each item produces one result: the cell row updates at the accept edge
// and the front/back words are then gathered from the row into the output
// register once the output is free. A new item is taken only once that
// gather is done, so the block does not take a new item before it is
// through with the last one. A refused push (full) or pop (empty) leaves
// the queue unchanged and reports overflow or underflow.
module double_ended_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] push_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] front_word_o,
  output logic [31:0] back_word_o,
  output logic [31:0] popped_word_o,
  output logic [4:0]  element_count_o,
  output logic        is_empty_o,
  output logic [1:0]  status_o
);
  import dq_pkg::*;

  logic [DEPTH-1:0]      cell_valid;
  logic [DEPTH-1:0]      cell_last;
  logic [WORD_WIDTH-1:0] cell_data [DEPTH];
  logic [WORD_WIDTH-1:0] push_word;
  logic [WORD_WIDTH-1:0] back_cur;
  cell_ctl_t             ctl;

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  pending_q;
  logic                  out_valid_q;
  logic [WORD_WIDTH-1:0] popped_q, popped_d;
  status_e               status_q, status_d;

  logic [31:0]           front_q, back_q, popped_out_q;
  logic [4:0]            count_out_q;
  logic                  empty_q;
  status_e               status_out_q;

  logic in_acc, out_free, full, empty;

  assign push_word  = push_value_i[WORD_WIDTH-1:0];
  assign in_stall_o = pending_q;
  assign in_acc     = in_valid_i && !pending_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  lv, rv;
    logic [WORD_WIDTH-1:0] ld, rd;
    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign ld = push_word;
    end else begin : g_mid_l
      assign lv = cell_valid[i-1];
      assign ld = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_mid_r
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
    end
    dq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .push_value_i  (push_word),
      .left_valid_i  (lv),
      .left_data_i   (ld),
      .right_valid_i (rv),
      .right_data_i  (rd),
      .valid_o       (cell_valid[i]),
      .data_o        (cell_data[i]),
      .last_o        (cell_last[i])
    );
  end

  // at most one cell is flagged last, so an AND-OR picks the back word
  always_comb begin
    back_cur = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_cur = back_cur | (cell_data[i] & {WORD_WIDTH{cell_last[i]}});
    end
  end

  always_comb begin
    ctl      = '0;
    count_d  = count_q;
    popped_d = '0;
    status_d = ST_OK;
    if (in_acc) begin
      case (operation_i)
        OP_PUSH_BACK: begin
          if (full) begin
            status_d = ST_OVER;
          end else begin
            ctl.add_back = 1'b1;
            count_d      = count_q + 1'b1;
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_OVER;
          end else begin
            ctl.add_front = 1'b1;
            count_d       = count_q + 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_d = ST_UNDER;
          end else begin
            ctl.take_back = 1'b1;
            popped_d      = back_cur;
            count_d       = count_q - 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_d = ST_UNDER;
          end else begin
            ctl.take_front = 1'b1;
            popped_d       = cell_data[0];
            count_d        = count_q - 1'b1;
          end
        end
        OP_CLEAR: begin
          ctl.clear = 1'b1;
          count_d   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        pending_q <= 1'b1;
      end else if (pending_q && out_free) begin
        pending_q <= 1'b0;
      end
      if (pending_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      popped_q <= popped_d;
      status_q <= status_d;
    end
    if (pending_q && out_free) begin
      front_q      <= cell_valid[0] ? 32'(cell_data[0]) : '0;
      back_q       <= 32'(back_cur);
      popped_out_q <= 32'(popped_q);
      count_out_q  <= 5'(count_q);
      empty_q      <= (count_q == '0);
      status_out_q <= status_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign front_word_o    = front_q;
  assign back_word_o     = back_q;
  assign popped_word_o   = popped_out_q;
  assign element_count_o = count_out_q;
  assign is_empty_o      = empty_q;
  assign status_o        = status_out_q;

`ifndef SYNTHESIS
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q))
    else $error("cell occupancy disagrees with count");

  a_single_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_last))
    else $error("more than one back cell");

  a_front_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) == cell_valid[0])
    else $error("queue not packed at cell 0");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !full && (operation_i == OP_PUSH_BACK || operation_i == OP_PUSH_FRONT))
    |=> (count_q == $past(count_q) + 1'b1))
    else $error("accepted push did not grow the queue");
`endif

endmodule

`default_nettype wire

// ----- tb/double_ended_queue_top_test.sv -----
`timescale 1ns / 1ps

module double_ended_queue_top_test;
  import dq_pkg::*;

  // codes outside the enum; the block treats them as a peek
  localparam logic [2:0] OP_RSVD_A = 3'd6;
  localparam logic [2:0] OP_RSVD_B = 3'd7;

  localparam int HOLD_OFF_CYCLES = 80;
  localparam int RANDOM_ITEMS    = 1500;
  localparam int DRAIN_CYCLES    = 8;

  typedef enum {FILL, DRAIN, MIXED} traffic_e;

  typedef struct packed {
    logic [31:0] front_word;
    logic [31:0] back_word;
    logic [31:0] popped_word;
    logic [4:0]  element_count;
    logic        is_empty;
    logic [1:0]  status;
  } deque_result_t;

  class deque_scoreboard;
    logic [31:0]   slots [DEPTH];
    int            head;
    int            count;
    deque_result_t pending [$];
    int            errors;

    function new();
      head   = 0;
      count  = 0;
      errors = 0;
    endfunction

    // apply one accepted operation to the shadow deque and queue its result
    function void note_input(logic [2:0] op, logic [31:0] value);
      deque_result_t r;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          if (count == DEPTH) begin
            r.status = ST_OVER;
          end else begin
            if (op == OP_PUSH_BACK) begin
              slots[(head + count) % DEPTH] = value;
            end else begin
              head = (head + DEPTH - 1) % DEPTH;
              slots[head] = value;
            end
            count++;
          end
        end
        OP_POP_BACK, OP_POP_FRONT: begin
          if (count == 0) begin
            r.status = ST_UNDER;
          end else begin
            if (op == OP_POP_BACK) begin
              r.popped_word = slots[(head + count - 1) % DEPTH];
            end else begin
              r.popped_word = slots[head];
              head = (head + 1) % DEPTH;
            end
            count--;
          end
        end
        OP_CLEAR: begin
          head  = 0;
          count = 0;
        end
        default: ;
      endcase
      if (count != 0) begin
        r.front_word = slots[head];
        r.back_word  = slots[(head + count - 1) % DEPTH];
      end
      r.element_count = count[4:0];
      r.is_empty      = (count == 0);
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(deque_result_t got);
      deque_result_t exp;
      if (pending.size() == 0) begin
        $error("result with no item outstanding: %p", got);
        errors++;
        return;
      end
      exp = pending[0];
      pending.delete(0);
      if (got.front_word !== exp.front_word) begin
        $error("front_word: expected %h, got %h", exp.front_word, got.front_word);
        errors++;
      end
      if (got.back_word !== exp.back_word) begin
        $error("back_word: expected %h, got %h", exp.back_word, got.back_word);
        errors++;
      end
      if (got.popped_word !== exp.popped_word) begin
        $error("popped_word: expected %h, got %h", exp.popped_word, got.popped_word);
        errors++;
      end
      if (got.element_count !== exp.element_count) begin
        $error("element_count: expected %0d, got %0d", exp.element_count,
               got.element_count);
        errors++;
      end
      if (got.is_empty !== exp.is_empty) begin
        $error("is_empty: expected %b, got %b", exp.is_empty, got.is_empty);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  operation_i;
  logic [31:0] push_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] front_word_o;
  logic [31:0] back_word_o;
  logic [31:0] popped_word_o;
  logic [4:0]  element_count_o;
  logic        is_empty_o;
  logic [1:0]  status_o;

  bit hold_off_req;
  bit no_idle;

  deque_scoreboard sb = new();

  double_ended_queue_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("double_ended_queue_top_test: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin : monitor
    deque_result_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(operation_i, push_value_i);
      if (out_valid_o && !out_stall_i) begin
        got = {front_word_o, back_word_o, popped_word_o, element_count_o,
               is_empty_o, status_o};
        sb.check_result(got);
      end
    end
  end

  // result side: random stalls, quiet stretches, and one long hold-off on request
  initial begin : receiver
    int len;
    out_stall_i = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (no_idle) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
        out_stall_i <= ($urandom_range(0, 2) == 0);
        repeat (len) @(posedge clk_i);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_op(traffic_e mode);
    int r;
    int push_lim;
    int pop_lim;
    r = $urandom_range(0, 99);
    case (mode)
      FILL:    begin push_lim = 80; pop_lim = 95; end
      DRAIN:   begin push_lim = 15; pop_lim = 95; end
      default: begin push_lim = 45; pop_lim = 90; end
    endcase
    if (r < push_lim) return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    if (r < pop_lim)  return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    case ($urandom_range(0, 3))
      0:       return OP_PEEK;
      1:       return OP_CLEAR;
      2:       return OP_RSVD_A;
      default: return OP_RSVD_B;
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(input logic [2:0] op, input logic [31:0] value);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    push_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin : stimulus
    traffic_e mode;
    int       sent;
    int       block_len;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    operation_i  = OP_PEEK;
    push_value_i = '0;
    hold_off_req = 1'b0;
    no_idle      = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty-queue corners, wrap of the head below zero, odd codes
    send_item(OP_PEEK, 32'h1234_5678);
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_item(OP_PUSH_BACK, 32'h0000_0000);
    send_item(OP_RSVD_A, 32'hDEAD_BEEF);
    send_item(OP_RSVD_B, 32'hDEAD_BEEF);
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_FRONT, '0);
    // fill to the top, then refused pushes at both ends
    for (int i = 0; i < DEPTH; i++) begin
      send_item(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, 32'hFFFF_FFFF >> i);
    end
    send_item(OP_PUSH_BACK, 32'hA5A5_A5A5);
    send_item(OP_PUSH_FRONT, 32'h5A5A_5A5A);
    send_item(OP_CLEAR, '0);

    // output held off while pushes keep coming, so the input backs up
    hold_off_req = 1'b1;
    no_idle      = 1'b1;
    for (int i = 0; i < 40; i++) send_item(pick_op(FILL), pick_word());
    no_idle = 1'b0;

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode      = traffic_e'($urandom_range(0, 2));
      no_idle   = ($urandom_range(0, 4) == 0);
      block_len = $urandom_range(10, 40);
      for (int i = 0; i < block_len; i++) begin
        send_item(pick_op(mode), pick_word());
        sent++;
      end
    end
    no_idle    = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("double_ended_queue_top_test: done, clean");
    end else begin
      $display("double_ended_queue_top_test: done, errors");
    end
    $finish;
  end

endmodule
